// ===== hdl/lrfbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrfbs_pkg
// Shared constants and payload layout for the rectangle fill byte sequencer.
// ----------------------------------------------------------------------------
package lrfbs_pkg;

	localparam int unsigned COORD_W   = 16;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned IN_DATA_W = 80;

	localparam logic [BYTE_W-1:0] CMD_COLUMN_SET = 8'h2A;
	localparam logic [BYTE_W-1:0] CMD_ROW_SET    = 8'h2B;
	localparam logic [BYTE_W-1:0] CMD_MEM_WRITE  = 8'h2C;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] fill_color;
		logic [COORD_W-1:0] rect_height;
		logic [COORD_W-1:0] rect_width;
		logic [COORD_W-1:0] y_origin;
		logic [COORD_W-1:0] x_origin;
	} rect_t;

endpackage
`default_nettype wire

// ===== hdl/lcd_rect_fill_byte_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_rect_fill_byte_sequencer
// Emits the 8080-bus byte stream that fills a rectangle with one color.
// ----------------------------------------------------------------------------
// One input transfer is taken every cycle unless a stalled output holds a
// tick in the input register. A start transfer latches the rectangle and
// gives no output; each tick transfer while a fill is running gives one
// bus byte: 0x2A and four column bytes, 0x2B and four row bytes, 0x2C,
// then a high and a low color byte per pixel. The last byte carries tlast.
// A tick waits in the input register and its byte then goes to the output register.
// Starts during a fill and ticks while idle are dropped.
module lcd_rect_fill_byte_sequencer (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	// x_origin[15:0], y_origin[31:16], rect_width[47:32],
	// rect_height[63:48], fill_color[79:64]
	input  wire  [lrfbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// op[0]
	input  wire                               s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	// bus_byte[7:0]
	output logic [lrfbs_pkg::BYTE_W-1:0]      m_axis_tdata,
	// is_command[0]
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast
);
	import lrfbs_pkg::*;

	typedef enum logic [3:0] {
		PH_CMD_COL,
		PH_COL_FIRST_HI,
		PH_COL_FIRST_LO,
		PH_COL_LAST_HI,
		PH_COL_LAST_LO,
		PH_CMD_ROW,
		PH_ROW_FIRST_HI,
		PH_ROW_FIRST_LO,
		PH_ROW_LAST_HI,
		PH_ROW_LAST_LO,
		PH_CMD_WRITE,
		PH_PIXELS
	} phase_t;

	logic               valid_s1;
	logic               op_s1;
	rect_t              rect_s1;

	phase_t             phase_q, phase_d;
	logic               busy_q, busy_d;
	logic               low_half_q, low_half_d;
	logic [COORD_W-1:0] col_count_q, col_count_d;
	logic [COORD_W-1:0] row_count_q, row_count_d;
	logic [COORD_W-1:0] col_first_q, col_last_q, row_first_q, row_last_q;
	logic [COORD_W-1:0] color_q, width_q, height_q;

	logic               produce;
	logic               advance;
	logic               latch;
	logic [BYTE_W-1:0]  res_byte;
	logic               res_cmd;
	logic               res_last;
	logic [COORD_W-1:0] col_inc;
	logic [COORD_W-1:0] row_inc;

	assign produce       = valid_s1 && (op_s1 == OP_TICK) && busy_q;
	assign advance       = valid_s1 && (!produce || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign latch         = advance && (op_s1 == OP_START) && !busy_q;
	assign col_inc       = col_count_q + 16'd1;
	assign row_inc       = row_count_q + 16'd1;

	always_comb begin
		phase_d     = phase_q;
		busy_d      = busy_q;
		low_half_d  = low_half_q;
		col_count_d = col_count_q;
		row_count_d = row_count_q;
		res_byte    = '0;
		res_cmd     = 1'b0;
		res_last    = 1'b0;
		if (latch) begin
			phase_d     = PH_CMD_COL;
			busy_d      = 1'b1;
			low_half_d  = 1'b0;
			col_count_d = '0;
			row_count_d = '0;
		end else if (advance && produce) begin
			case (phase_q)
				PH_CMD_COL: begin
					res_byte = CMD_COLUMN_SET;
					res_cmd  = 1'b1;
					phase_d  = PH_COL_FIRST_HI;
				end
				PH_COL_FIRST_HI: begin
					res_byte = col_first_q[15:8];
					phase_d  = PH_COL_FIRST_LO;
				end
				PH_COL_FIRST_LO: begin
					res_byte = col_first_q[7:0];
					phase_d  = PH_COL_LAST_HI;
				end
				PH_COL_LAST_HI: begin
					res_byte = col_last_q[15:8];
					phase_d  = PH_COL_LAST_LO;
				end
				PH_COL_LAST_LO: begin
					res_byte = col_last_q[7:0];
					phase_d  = PH_CMD_ROW;
				end
				PH_CMD_ROW: begin
					res_byte = CMD_ROW_SET;
					res_cmd  = 1'b1;
					phase_d  = PH_ROW_FIRST_HI;
				end
				PH_ROW_FIRST_HI: begin
					res_byte = row_first_q[15:8];
					phase_d  = PH_ROW_FIRST_LO;
				end
				PH_ROW_FIRST_LO: begin
					res_byte = row_first_q[7:0];
					phase_d  = PH_ROW_LAST_HI;
				end
				PH_ROW_LAST_HI: begin
					res_byte = row_last_q[15:8];
					phase_d  = PH_ROW_LAST_LO;
				end
				PH_ROW_LAST_LO: begin
					res_byte = row_last_q[7:0];
					phase_d  = PH_CMD_WRITE;
				end
				PH_CMD_WRITE: begin
					res_byte = CMD_MEM_WRITE;
					res_cmd  = 1'b1;
					if (width_q == '0 || height_q == '0) begin
						res_last = 1'b1;
						busy_d   = 1'b0;
						phase_d  = PH_CMD_COL;
					end else begin
						phase_d  = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (!low_half_q) begin
						res_byte   = color_q[15:8];
						low_half_d = 1'b1;
					end else begin
						res_byte    = color_q[7:0];
						low_half_d  = 1'b0;
						col_count_d = col_inc;
						if (col_inc == width_q) begin
							col_count_d = '0;
							row_count_d = row_inc;
							if (row_inc == height_q) begin
								res_last    = 1'b1;
								busy_d      = 1'b0;
								phase_d     = PH_CMD_COL;
								row_count_d = '0;
							end
						end
					end
				end
				default: begin
					phase_d = PH_CMD_COL;
					busy_d  = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			phase_q       <= PH_CMD_COL;
			busy_q        <= 1'b0;
			low_half_q    <= 1'b0;
			col_count_q   <= '0;
			row_count_q   <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			phase_q     <= phase_d;
			busy_q      <= busy_d;
			low_half_q  <= low_half_d;
			col_count_q <= col_count_d;
			row_count_q <= row_count_d;
			if (advance && produce) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser;
			rect_s1 <= rect_t'(s_axis_tdata);
		end
		if (latch) begin
			col_first_q <= rect_s1.x_origin;
			col_last_q  <= rect_s1.x_origin + rect_s1.rect_width - 16'd1;
			row_first_q <= rect_s1.y_origin;
			row_last_q  <= rect_s1.y_origin + rect_s1.rect_height - 16'd1;
			width_q     <= rect_s1.rect_width;
			height_q    <= rect_s1.rect_height;
			color_q     <= rect_s1.fill_color;
		end
		if (advance && produce) begin
			m_axis_tdata <= res_byte;
			m_axis_tuser <= res_cmd;
			m_axis_tlast <= res_last;
		end
	end

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (phase_q == PH_CMD_COL && !low_half_q))
		else $error("idle sequencer holds a nonzero phase");

	a_low_half_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		low_half_q |-> (phase_q == PH_PIXELS))
		else $error("low color half pending outside the pixel phase");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && phase_q == PH_PIXELS) |-> (col_count_q != width_q))
		else $error("column count reached the rectangle width");

	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == CMD_COLUMN_SET ||
		m_axis_tdata == CMD_ROW_SET || m_axis_tdata == CMD_MEM_WRITE))
		else $error("command transfer carries an unknown code");

	a_last_ends_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && produce && res_last) |=> !busy_q)
		else $error("fill still running after its last byte");

endmodule
`default_nettype wire

// ===== test/lcd_rect_fill_byte_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_rect_fill_byte_sequencer_test
// Self-checking bench for the rectangle fill byte sequencer. A queue of start
// and tick transfers feeds the input stream with random idle bursts. Each
// accepted transfer steps a local copy of the sequencer state, which queues
// the byte the block owes. The output stream is stalled at random, and every
// byte taken is checked field by field against the oldest byte owed.
// ----------------------------------------------------------------------------
module lcd_rect_fill_byte_sequencer_test;
	import lrfbs_pkg::*;

	localparam int unsigned RUN_ITEMS  = 730;
	localparam int unsigned TAIL_ITEMS = 80;
	localparam int unsigned LIMIT      = 200000;
	localparam int unsigned PH_PIXELS  = 11;

	typedef struct {
		logic  op;
		rect_t rect;
	} fill_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] bus_byte;
		logic              is_command;
		logic              last_byte;
	} bus_write_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 s_axis_tvalid  = 1'b0;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata   = '0;
	logic                 s_axis_tuser   = OP_TICK;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready  = 1'b0;
	logic [BYTE_W-1:0]    m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;

	fill_item_t  pending_items[$];
	bus_write_t  bytes_due[$];
	int unsigned errors      = 0;
	int unsigned cycle_count = 0;
	int unsigned src_gap     = 0;
	int unsigned snk_gap     = 0;

	// sequencer state mirror
	int unsigned        phase;
	logic [COORD_W-1:0] col_first, col_last, row_first, row_last;
	logic [COORD_W-1:0] held_color, held_width, held_height;
	logic [COORD_W-1:0] col_count, row_count;
	logic               low_half_next;
	logic               busy;

	lcd_rect_fill_byte_sequencer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic step_sequencer(input logic op, input rect_t r);
		bus_write_t w;
		w = '0;
		if (op == OP_START) begin
			if (!busy) begin
				col_first     = r.x_origin;
				col_last      = r.x_origin + r.rect_width - 16'd1;
				row_first     = r.y_origin;
				row_last      = r.y_origin + r.rect_height - 16'd1;
				held_width    = r.rect_width;
				held_height   = r.rect_height;
				held_color    = r.fill_color;
				col_count     = '0;
				row_count     = '0;
				low_half_next = 1'b0;
				phase         = 0;
				busy          = 1'b1;
			end
		end else if (busy) begin
			case (phase)
				0: begin
					w.bus_byte   = CMD_COLUMN_SET;
					w.is_command = 1'b1;
				end
				1: w.bus_byte = col_first[15:8];
				2: w.bus_byte = col_first[7:0];
				3: w.bus_byte = col_last[15:8];
				4: w.bus_byte = col_last[7:0];
				5: begin
					w.bus_byte   = CMD_ROW_SET;
					w.is_command = 1'b1;
				end
				6: w.bus_byte = row_first[15:8];
				7: w.bus_byte = row_first[7:0];
				8: w.bus_byte = row_last[15:8];
				9: w.bus_byte = row_last[7:0];
				10: begin
					w.bus_byte   = CMD_MEM_WRITE;
					w.is_command = 1'b1;
					if (held_width == 0 || held_height == 0) begin
						w.last_byte = 1'b1;
						busy        = 1'b0;
						phase       = 0;
					end
				end
				default: begin
					if (!low_half_next) begin
						w.bus_byte    = held_color[15:8];
						low_half_next = 1'b1;
					end else begin
						w.bus_byte    = held_color[7:0];
						low_half_next = 1'b0;
						col_count     = col_count + 16'd1;
						if (col_count == held_width) begin
							col_count = '0;
							row_count = row_count + 16'd1;
							if (row_count == held_height) begin
								w.last_byte = 1'b1;
								busy        = 1'b0;
								phase       = 0;
								row_count   = '0;
							end
						end
					end
				end
			endcase
			if (busy && phase < PH_PIXELS)
				phase = phase + 1;
			bytes_due.push_back(w);
		end
	endtask

	function automatic rect_t random_rect();
		rect_t r;
		r.x_origin    = 16'($urandom_range(0, 16'hFFFF));
		r.y_origin    = 16'($urandom_range(0, 16'hFFFF));
		r.rect_width  = 16'($urandom_range(0, 16'hFFFF));
		r.rect_height = 16'($urandom_range(0, 16'hFFFF));
		r.fill_color  = 16'($urandom_range(0, 16'hFFFF));
		return r;
	endfunction

	task automatic push_start(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] w, input logic [15:0] h, input logic [15:0] c);
		fill_item_t it;
		it.op   = OP_START;
		it.rect = '{fill_color: c, rect_height: h, rect_width: w, y_origin: y, x_origin: x};
		pending_items.push_back(it);
	endtask

	task automatic push_ticks(input int unsigned count);
		fill_item_t it;
		it.op = OP_TICK;
		repeat (count) begin
			it.rect = random_rect();
			pending_items.push_back(it);
		end
	endtask

	task automatic push_noise_start();
		fill_item_t it;
		it.op   = OP_START;
		it.rect = random_rect();
		pending_items.push_back(it);
	endtask

	// input side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= OP_TICK;
			src_gap       <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				step_sequencer(s_axis_tuser, rect_t'(s_axis_tdata));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap != 0) begin
					s_axis_tvalid <= 1'b0;
					src_gap       <= src_gap - 1;
				end else if (pending_items.size() >= TAIL_ITEMS &&
						$urandom_range(0, 5) == 0) begin
					s_axis_tvalid <= 1'b0;
					src_gap       <= $urandom_range(0, 10);
				end else if (pending_items.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_items[0].rect;
					s_axis_tuser  <= pending_items[0].op;
					void'(pending_items.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// output side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			snk_gap       <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (bytes_due.size() == 0) begin
					$error("unexpected transfer: bus_byte %h is_command %b last_byte %b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					if (m_axis_tdata !== bytes_due[0].bus_byte) begin
						$error("bus_byte: expected %h, got %h",
							bytes_due[0].bus_byte, m_axis_tdata);
						errors++;
					end
					if (m_axis_tuser !== bytes_due[0].is_command) begin
						$error("is_command: expected %b, got %b",
							bytes_due[0].is_command, m_axis_tuser);
						errors++;
					end
					if (m_axis_tlast !== bytes_due[0].last_byte) begin
						$error("last_byte: expected %b, got %b",
							bytes_due[0].last_byte, m_axis_tlast);
						errors++;
					end
					void'(bytes_due.pop_front());
				end
			end
			if (snk_gap != 0) begin
				m_axis_tready <= 1'b0;
				snk_gap       <= snk_gap - 1;
			end else if (pending_items.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				snk_gap       <= $urandom_range(0, 10);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("FAIL lcd_rect_fill_byte_sequencer");
			$finish;
		end
	end

	initial begin
		int unsigned  w, h, need, sel;
		phase         = 0;
		col_first     = '0;
		col_last      = '0;
		row_first     = '0;
		row_last      = '0;
		held_color    = '0;
		held_width    = '0;
		held_height   = '0;
		col_count     = '0;
		row_count     = '0;
		low_half_next = 1'b0;
		busy          = 1'b0;

		// tick while idle, row end wrapping past 0xFFFF, start during a fill
		push_ticks(1);
		push_start(16'hFFFF, 16'hFFFF, 16'd1, 16'd2, 16'hA5C3);
		push_ticks(3);
		push_start(16'h0000, 16'h0000, 16'd3, 16'd3, 16'h0000);
		push_ticks(12);
		// empty rectangle: widest column span, no rows
		push_start(16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 16'hFFFF);
		push_ticks(12);

		while (pending_items.size() < RUN_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				if ($urandom_range(0, 1) == 0) begin
					w = $urandom_range(0, 16'hFFFF);
					h = 0;
				end else begin
					w = 0;
					h = $urandom_range(0, 16'hFFFF);
				end
			end else begin
				w = $urandom_range(0, 4);
				h = $urandom_range(0, 4);
			end
			need = 11 + 2 * w * h;
			sel  = $urandom_range(0, 99);
			push_start(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
				16'(w), 16'(h), 16'($urandom_range(0, 16'hFFFF)));
			if (sel < 85) begin
				repeat (need) begin
					if ($urandom_range(0, 9) == 0)
						push_noise_start();
					push_ticks(1);
				end
				if ($urandom_range(0, 4) == 0)
					push_ticks(1);
			end else begin
				push_ticks($urandom_range(0, need));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || s_axis_tvalid || bytes_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (errors == 0)
			$display("PASS lcd_rect_fill_byte_sequencer");
		else
			$display("FAIL lcd_rect_fill_byte_sequencer");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lrfbs_pkg.sv
hdl/lcd_rect_fill_byte_sequencer.sv
test/lcd_rect_fill_byte_sequencer_test.sv
